// ===== hw/rtl/bftl_pkg.sv =====
package bftl_pkg;

    localparam int GLYPH_SLOTS = 128;
    localparam int FIRST_CHAR  = 33;
    localparam int COORD_BITS  = 16;

    localparam int SLOT_BITS  = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
    localparam int SUM_BITS   = COORD_BITS + 2;
    localparam int ADD_BITS   = 13;
    localparam int LINE_GAP   = 3;
    localparam int SRC_ROW0   = 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [SUM_BITS-1:0]   wide_t;

    localparam coord_t PEN_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    localparam logic [1:0] OP_TABLE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_CHAR  = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;

    localparam logic [2:0] REG_SPACE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MAX_CHAR     = 3'd2;
    localparam logic [2:0] REG_CLIP_ENABLE  = 3'd3;
    localparam logic [2:0] REG_CLIP_LEFT    = 3'd4;
    localparam logic [2:0] REG_CLIP_TOP     = 3'd5;
    localparam logic [2:0] REG_CLIP_WIDTH   = 3'd6;
    localparam logic [2:0] REG_CLIP_HEIGHT  = 3'd7;

    typedef enum logic [1:0] {
        KIND_OTHER   = 2'd0,
        KIND_SPACE   = 2'd1,
        KIND_NEWLINE = 2'd2,
        KIND_GLYPH   = 2'd3
    } char_kind_t;

    typedef struct packed {
        logic         draw;
        logic [15:0]  src_x;
        logic [15:0]  src_y;
        logic [11:0]  src_width;
        logic [11:0]  src_height;
        coord_t       dst_x;
        coord_t       dst_y;
    } glyph_t;

    typedef struct packed {
        logic         enable;
        coord_t       left;
        coord_t       top;
        logic [14:0]  width;
        logic [14:0]  height;
    } clip_cfg_t;

    function automatic coord_t pen_add(input coord_t base, input logic [ADD_BITS-1:0] amt);
        wide_t sum;
        sum = SUM_BITS'(base) + $signed(SUM_BITS'(amt));
        if (sum > SUM_BITS'(PEN_MAX))
            return PEN_MAX;
        return COORD_BITS'(sum);
    endfunction

endpackage

// ===== hw/rtl/bftl_if.sv =====
interface bftl_item_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    logic [7:0]           char_code;
    logic [6:0]           glyph_index;
    logic [11:0]          glyph_left;
    logic [11:0]          glyph_advance;
    bftl_pkg::coord_t     start_x;
    bftl_pkg::coord_t     start_y;

    modport source(output valid, opcode, char_code, glyph_index, glyph_left, glyph_advance,
                   start_x, start_y, input ready);
    modport sink(input valid, opcode, char_code, glyph_index, glyph_left, glyph_advance,
                 start_x, start_y, output ready);
endinterface

interface bftl_result_if;
    logic                 valid;
    logic                 ready;
    logic                 draw;
    logic [15:0]          src_x;
    logic [15:0]          src_y;
    logic [11:0]          src_width;
    logic [11:0]          src_height;
    bftl_pkg::coord_t     dst_x;
    bftl_pkg::coord_t     dst_y;

    modport source(output valid, draw, src_x, src_y, src_width, src_height, dst_x, dst_y,
                   input ready);
    modport sink(input valid, draw, src_x, src_y, src_width, src_height, dst_x, dst_y,
                 output ready);
endinterface

interface bftl_cfg_if;
    logic         valid;
    logic         ready;
    logic [2:0]   index;
    logic [15:0]  data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bftl_clip.sv =====
module bftl_clip (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bftl_pkg::glyph_t     glyph,
    input  bftl_pkg::clip_cfg_t  clip,
    bftl_result_if.source        result
);

    typedef struct packed {
        logic                 draw;
        logic [15:0]          src_x;
        logic [15:0]          src_y;
        bftl_pkg::coord_t     dst_x;
        bftl_pkg::coord_t     dst_y;
        bftl_pkg::wide_t      width;
        bftl_pkg::wide_t      height;
    } clip_mid_t;

    logic               a_valid_reg;
    bftl_pkg::glyph_t   a_reg;
    logic               b_valid_reg;
    clip_mid_t          b_reg;
    clip_mid_t          b_next;
    logic               out_valid_reg;
    bftl_pkg::glyph_t   out_reg;
    bftl_pkg::glyph_t   out_next;
    logic               out_ready;
    logic               b_ready;

    bftl_pkg::wide_t    ex;
    bftl_pkg::wide_t    ey;
    logic               ex_pos;
    logic               ey_pos;
    bftl_pkg::wide_t    lim_w;
    bftl_pkg::wide_t    lim_h;
    bftl_pkg::wide_t    w;
    bftl_pkg::wide_t    h;

    assign out_ready = !out_valid_reg || result.ready;
    assign b_ready   = !b_valid_reg || out_ready;
    assign in_ready  = !a_valid_reg || b_ready;

    // left/top edge
    always_comb
    begin
        ex     = bftl_pkg::SUM_BITS'(clip.left) - bftl_pkg::SUM_BITS'(a_reg.dst_x);
        ey     = bftl_pkg::SUM_BITS'(clip.top) - bftl_pkg::SUM_BITS'(a_reg.dst_y);
        ex_pos = clip.enable && !ex[bftl_pkg::SUM_BITS-1] && (ex != '0);
        ey_pos = clip.enable && !ey[bftl_pkg::SUM_BITS-1] && (ey != '0);

        b_next.draw   = a_reg.draw;
        b_next.src_x  = a_reg.src_x;
        b_next.src_y  = a_reg.src_y;
        b_next.dst_x  = a_reg.dst_x;
        b_next.dst_y  = a_reg.dst_y;
        b_next.width  = $signed(bftl_pkg::SUM_BITS'(a_reg.src_width));
        b_next.height = $signed(bftl_pkg::SUM_BITS'(a_reg.src_height));
        if (ex_pos)
        begin
            b_next.src_x = a_reg.src_x + ex[15:0];
            b_next.dst_x = clip.left;
            b_next.width = b_next.width - ex;
        end
        if (ey_pos)
        begin
            b_next.src_y = a_reg.src_y + ey[15:0];
            b_next.dst_y = clip.top;
            b_next.height = b_next.height - ey;
        end
    end

    // right/bottom edge, floor at zero
    always_comb
    begin
        lim_w = bftl_pkg::SUM_BITS'(clip.left) + $signed(bftl_pkg::SUM_BITS'(clip.width))
                - bftl_pkg::SUM_BITS'(b_reg.dst_x);
        lim_h = bftl_pkg::SUM_BITS'(clip.top) + $signed(bftl_pkg::SUM_BITS'(clip.height))
                - bftl_pkg::SUM_BITS'(b_reg.dst_y);
        w = b_reg.width;
        h = b_reg.height;
        if (clip.enable && (w > lim_w))
            w = lim_w;
        if (clip.enable && (h > lim_h))
            h = lim_h;
        if (w[bftl_pkg::SUM_BITS-1])
            w = '0;
        if (h[bftl_pkg::SUM_BITS-1])
            h = '0;

        out_next = '0;
        if (b_reg.draw)
        begin
            out_next.draw       = 1'b1;
            out_next.src_x      = b_reg.src_x;
            out_next.src_y      = b_reg.src_y;
            out_next.src_width  = w[11:0];
            out_next.src_height = h[11:0];
            out_next.dst_x      = b_reg.dst_x;
            out_next.dst_y      = b_reg.dst_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (out_ready)
                out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            a_reg <= glyph;
        if (b_ready && a_valid_reg)
            b_reg <= b_next;
        if (out_ready && b_valid_reg)
            out_reg <= out_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.draw       = out_reg.draw;
    assign result.src_x      = out_reg.src_x;
    assign result.src_y      = out_reg.src_y;
    assign result.src_width  = out_reg.src_width;
    assign result.src_height = out_reg.src_height;
    assign result.dst_x      = out_reg.dst_x;
    assign result.dst_y      = out_reg.dst_y;

endmodule

// ===== hw/rtl/bitmap_font_text_layout.sv =====
// Text layout for a proportional bitmap font strip: takes one item per clock (glyph table
// write, string start or character) unless the clip stage stalls, and returns one result
// per character, with space, newline and unknown codes giving a result with draw low. The
// glyph left and advance tables are on-chip RAMs read when an item is taken; the pen is
// updated from the registered read data when the item leaves the intake register. Clipping
// follows in registered stages, the last of which is the output register.
// Table contents are undefined after reset until written; load every slot a string uses.
module bitmap_font_text_layout (
    input  logic           clk,
    input  logic           rst_n,
    bftl_item_if.sink      item,
    bftl_result_if.source  result,
    bftl_cfg_if.sink       cfg
);

    logic [11:0] left_mem [bftl_pkg::GLYPH_SLOTS];
    logic [11:0] adv_mem  [bftl_pkg::GLYPH_SLOTS];

    logic [11:0]          space_width_reg;
    logic [11:0]          glyph_height_reg;
    logic [6:0]           max_char_reg;
    bftl_pkg::clip_cfg_t  clip_reg;

    logic [11:0]          left0_reg;
    logic [11:0]          left1_reg;
    logic [11:0]          adv_reg;

    logic                 s1_valid_reg;
    logic [1:0]           s1_op_reg;
    bftl_pkg::char_kind_t s1_kind_reg;
    bftl_pkg::coord_t     s1_start_x_reg;
    bftl_pkg::coord_t     s1_start_y_reg;

    bftl_pkg::coord_t     pen_x_reg;
    bftl_pkg::coord_t     pen_x_next;
    bftl_pkg::coord_t     pen_y_reg;
    bftl_pkg::coord_t     pen_y_next;
    bftl_pkg::coord_t     line_x_reg;
    bftl_pkg::coord_t     line_x_next;

    logic                 accept;
    logic [8:0]           ofs;
    logic [bftl_pkg::SLOT_BITS-1:0] rd_addr0;
    logic [bftl_pkg::SLOT_BITS-1:0] rd_addr1;
    logic [bftl_pkg::SLOT_BITS-1:0] wr_addr;
    logic                 wr_en;
    bftl_pkg::char_kind_t kind;

    logic                 s1_has_result;
    logic                 s1_fire;
    logic                 clip_ready;
    logic [12:0]          raw_width;
    bftl_pkg::glyph_t     glyph;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_width_reg  <= '0;
            glyph_height_reg <= '0;
            max_char_reg     <= '0;
            clip_reg         <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                bftl_pkg::REG_SPACE_WIDTH:  space_width_reg  <= cfg.data[11:0];
                bftl_pkg::REG_GLYPH_HEIGHT: glyph_height_reg <= cfg.data[11:0];
                bftl_pkg::REG_MAX_CHAR:     max_char_reg     <= cfg.data[6:0];
                bftl_pkg::REG_CLIP_ENABLE:  clip_reg.enable  <= cfg.data[0];
                bftl_pkg::REG_CLIP_LEFT:    clip_reg.left    <= $signed(cfg.data);
                bftl_pkg::REG_CLIP_TOP:     clip_reg.top     <= $signed(cfg.data);
                bftl_pkg::REG_CLIP_WIDTH:   clip_reg.width   <= cfg.data[14:0];
                bftl_pkg::REG_CLIP_HEIGHT:  clip_reg.height  <= cfg.data[14:0];
                default: ;
            endcase
        end
    end

    // item intake: classify and issue table reads
    assign s1_has_result = (s1_op_reg == bftl_pkg::OP_CHAR);
    assign s1_fire       = s1_valid_reg && (!s1_has_result || clip_ready);
    assign item.ready    = !s1_valid_reg || s1_fire;
    assign accept        = item.valid && item.ready;

    always_comb
    begin
        ofs      = {1'b0, item.char_code} - 9'(bftl_pkg::FIRST_CHAR);
        rd_addr0 = bftl_pkg::SLOT_BITS'(ofs);
        rd_addr1 = bftl_pkg::SLOT_BITS'(ofs + 9'd1);
        wr_addr  = bftl_pkg::SLOT_BITS'(item.glyph_index);
        wr_en    = accept && (item.opcode == bftl_pkg::OP_TABLE)
                   && ({2'b0, item.glyph_index} < 9'(bftl_pkg::GLYPH_SLOTS));
        if (item.char_code == bftl_pkg::CHAR_SPACE)
            kind = bftl_pkg::KIND_SPACE;
        else if (item.char_code == bftl_pkg::CHAR_NEWLINE)
            kind = bftl_pkg::KIND_NEWLINE;
        else if ((item.char_code >= 8'(bftl_pkg::FIRST_CHAR))
                 && (item.char_code <= {1'b0, max_char_reg})
                 && ((ofs + 9'd1) < 9'(bftl_pkg::GLYPH_SLOTS)))
            kind = bftl_pkg::KIND_GLYPH;
        else
            kind = bftl_pkg::KIND_OTHER;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_addr] <= item.glyph_left;
            adv_mem[wr_addr]  <= item.glyph_advance;
        end
        if (accept)
        begin
            left0_reg <= left_mem[rd_addr0];
            left1_reg <= left_mem[rd_addr1];
            adv_reg   <= adv_mem[rd_addr0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item.ready)
            s1_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg      <= item.opcode;
            s1_kind_reg    <= kind;
            s1_start_x_reg <= item.start_x;
            s1_start_y_reg <= item.start_y;
        end
    end

    // pen update and glyph rectangle
    always_comb
    begin
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        line_x_next = line_x_reg;
        if (s1_fire && (s1_op_reg == bftl_pkg::OP_START))
        begin
            pen_x_next  = s1_start_x_reg;
            line_x_next = s1_start_x_reg;
            pen_y_next  = s1_start_y_reg;
        end
        else if (s1_fire && s1_has_result)
        begin
            unique case (s1_kind_reg)
                bftl_pkg::KIND_SPACE:
                    pen_x_next = bftl_pkg::pen_add(pen_x_reg, {1'b0, space_width_reg});
                bftl_pkg::KIND_NEWLINE:
                begin
                    pen_x_next = line_x_reg;
                    pen_y_next = bftl_pkg::pen_add(pen_y_reg,
                        {1'b0, glyph_height_reg} + 13'(bftl_pkg::LINE_GAP));
                end
                bftl_pkg::KIND_GLYPH:
                    pen_x_next = bftl_pkg::pen_add(pen_x_reg, {1'b0, adv_reg});
                default: ;
            endcase
        end

        raw_width = {1'b0, left1_reg} - {1'b0, left0_reg};
        glyph     = '0;
        if (s1_kind_reg == bftl_pkg::KIND_GLYPH)
        begin
            glyph.draw       = 1'b1;
            glyph.src_x      = 16'(left0_reg);
            glyph.src_y      = 16'(bftl_pkg::SRC_ROW0);
            glyph.src_width  = raw_width[12] ? 12'd0 : raw_width[11:0];
            glyph.src_height = glyph_height_reg;
            glyph.dst_x      = pen_x_reg;
            glyph.dst_y      = pen_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            line_x_reg <= '0;
        end
        else
        begin
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            line_x_reg <= line_x_next;
        end
    end

    bftl_clip u_clip (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid_reg && s1_has_result),
        .in_ready (clip_ready),
        .glyph    (glyph),
        .clip     (clip_reg),
        .result   (result)
    );

endmodule
